// ----- rtl/core/tpcl_pkg.sv -----
package tpcl_pkg;

   // fixed field widths of the ports
   localparam int KEY_W       = 64;
   localparam int COUNT_OUT_W = 16;
   localparam int OCC_W       = 5;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_IDX_W   = 1;
   localparam int CAP_REG_W   = 5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HIT_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY      = 1'd1;

   // register reset values
   localparam logic [CSR_DATA_W-1:0] HIT_THRESHOLD_RESET = 16'd4;
   localparam logic [CAP_REG_W-1:0]  CAPACITY_RESET      = 5'd16;

   // per-cell control from the sequencer
   typedef struct packed {
      logic look;   // compare the broadcast key and latch the match
      logic shift;  // take the entry of the left neighbour
      logic bump;   // write the broadcast count in place
   } tpcl_ctrl_type;

endpackage

// ----- rtl/core/tpcl_cell.sv -----
module tpcl_cell #(
   parameter int KEY_BITS   = 64,
   parameter int COUNT_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tpcl_pkg::tpcl_ctrl_type ctrl,
   input  logic [KEY_BITS-1:0]    look_key,
   input  logic [COUNT_BITS-1:0]  upd_count,
   input  logic [KEY_BITS-1:0]    left_key,
   input  logic [COUNT_BITS-1:0]  left_count,
   input  logic                   left_valid,
   output logic [KEY_BITS-1:0]    key_q,
   output logic [COUNT_BITS-1:0]  count_q,
   output logic                   valid_q,
   output logic                   match_q
);
   import tpcl_pkg::*;

   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  valid_ff, valid_in;
   logic                  match_ff, match_in;

   always_comb begin
      key_in   = key_ff;
      count_in = count_ff;
      valid_in = valid_ff;
      match_in = match_ff;
      if (ctrl.look) begin
         match_in = valid_ff && (key_ff == look_key);
      end
      if (ctrl.shift) begin
         key_in   = left_key;
         count_in = left_count;
         valid_in = left_valid;
      end else if (ctrl.bump) begin
         count_in = upd_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
      key_ff   <= key_in;
      count_ff <= count_in;
   end

   assign key_q   = key_ff;
   assign count_q = count_ff;
   assign valid_q = valid_ff;
   assign match_q = match_ff;

endmodule

// ----- rtl/core/threshold_promoted_cache_list_unit.sv -----
// Ordered key cache with hit counters and promotion to the front above a threshold.
// Request channel: req_valid/req_ready with req_key; only the low KEY_BITS bits
// take part. Response channel: rsp_valid/rsp_ready with hit, promoted, hit_count,
// evicted, evicted_key and occupancy, exactly one response per request.
// Configuration: a write on csr_write_en sets hit_threshold (index 0) or
// capacity (index 1, 0 acts as 1, above CAPACITY acts as CAPACITY).
// The entries sit in a row of cells ordered front first. On the request transfer
// every cell compares the key and latches its match; once the output register is
// free, the row updates at once: cells up to the insert point take their left
// neighbour's entry, cell 0 takes the new or promoted entry, or the hit cell
// updates its count. The block takes a new request only after the previous
// update; req_ready is high only while the block waits for a key. Reset empties
// the cache and restores threshold 4 and capacity 16; no clearing pass is needed.
// If the receiver stalls with a response pending, the update cycle of the
// following request waits until the output register frees up.
module threshold_promoted_cache_list_unit #(
   parameter int CAPACITY   = 16,
   parameter int KEY_BITS   = 64,
   parameter int COUNT_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [tpcl_pkg::KEY_W-1:0]           req_key,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_hit,
   output logic                                 rsp_promoted,
   output logic [tpcl_pkg::COUNT_OUT_W-1:0]     rsp_hit_count,
   output logic                                 rsp_evicted,
   output logic [tpcl_pkg::KEY_W-1:0]           rsp_evicted_key,
   output logic [tpcl_pkg::OCC_W-1:0]           rsp_occupancy,
   input  logic                                 csr_write_en,
   input  logic [tpcl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tpcl_pkg::CSR_DATA_W-1:0]      csr_data
);
   import tpcl_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int HW    = $clog2(CAPACITY + 1);
   localparam int CW    = (HW > CAP_REG_W) ? HW : CAP_REG_W;
   localparam int TW    = (COUNT_BITS > CSR_DATA_W) ? COUNT_BITS : CSR_DATA_W;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   state_type                state_ff, state_in;
   logic [KEY_BITS-1:0]      key_ff, key_in;
   logic [HW-1:0]            held_ff, held_in;
   logic [CSR_DATA_W-1:0]    thr_ff, thr_in;
   logic [CAP_REG_W-1:0]     cap_ff, cap_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     hit_ff, hit_in;
   logic                     promoted_ff, promoted_in;
   logic [COUNT_OUT_W-1:0]   count_ff, count_in;
   logic                     evicted_ff, evicted_in;
   logic [KEY_W-1:0]         ev_key_ff, ev_key_in;
   logic [OCC_W-1:0]         occ_ff, occ_in;

   // cell row signals
   tpcl_ctrl_type            cell_ctrl  [CAPACITY];
   logic [KEY_BITS-1:0]      cell_key   [CAPACITY];
   logic [COUNT_BITS-1:0]    cell_count [CAPACITY];
   logic                     cell_valid [CAPACITY];
   logic [CAPACITY-1:0]      match;

   logic                     accept, fire, hit, promote, full, move;
   logic [IDX_W-1:0]         pos;
   logic [COUNT_BITS-1:0]    sel_count, inc_count, new_count;
   logic [KEY_BITS-1:0]      rear_key;
   logic [HW-1:0]            slot_pos;
   logic [CW-1:0]            cap_wide;
   logic [HW-1:0]            cap_eff;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign fire      = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ready);

   // match vector is one-hot at most: keys in the row are unique
   always_comb begin
      pos       = '0;
      sel_count = '0;
      rear_key  = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         pos       = pos | (IDX_W'(i) & {IDX_W{match[i]}});
         sel_count = sel_count | (cell_count[i] & {COUNT_BITS{match[i]}});
         rear_key  = rear_key | (cell_key[i] & {KEY_BITS{HW'(i) == held_ff - HW'(1)}});
      end
   end

   always_comb begin
      cap_wide = CW'(cap_ff);
      if (cap_wide == '0) begin
         cap_eff = HW'(1);
      end else if (cap_wide > CW'(CAPACITY)) begin
         cap_eff = HW'(CAPACITY);
      end else begin
         cap_eff = HW'(cap_wide);
      end
   end

   assign hit       = |match;
   assign inc_count = (sel_count == COUNT_MAX) ? sel_count : sel_count + COUNT_BITS'(1);
   assign new_count = hit ? inc_count : COUNT_BITS'(1);
   assign promote   = hit && (TW'(inc_count) > TW'(thr_ff)) && (pos != '0);
   assign full      = (held_ff >= cap_eff);
   assign move      = promote || !hit;

   always_comb begin
      if (hit) begin
         slot_pos = HW'(pos);
      end else if (full) begin
         slot_pos = held_ff - HW'(1);
      end else begin
         slot_pos = held_ff;
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [KEY_BITS-1:0]   left_key;
      logic [COUNT_BITS-1:0] left_count;
      logic                  left_valid;

      if (g == 0) begin : g_head
         // the front cell takes the new or promoted entry
         assign left_key   = key_ff;
         assign left_count = new_count;
         assign left_valid = 1'b1;
      end else begin : g_body
         assign left_key   = cell_key[g-1];
         assign left_count = cell_count[g-1];
         assign left_valid = cell_valid[g-1];
      end

      assign cell_ctrl[g].look  = accept;
      assign cell_ctrl[g].shift = fire && move && (HW'(g) <= slot_pos);
      assign cell_ctrl[g].bump  = fire && hit && !promote && match[g];

      tpcl_cell #(
         .KEY_BITS   (KEY_BITS),
         .COUNT_BITS (COUNT_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl[g]),
         .look_key   (req_key[KEY_BITS-1:0]),
         .upd_count  (new_count),
         .left_key   (left_key),
         .left_count (left_count),
         .left_valid (left_valid),
         .key_q      (cell_key[g]),
         .count_q    (cell_count[g]),
         .valid_q    (cell_valid[g]),
         .match_q    (match[g])
      );
   end

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      held_in      = held_ff;
      thr_in       = thr_ff;
      cap_in       = cap_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      hit_in       = hit_ff;
      promoted_in  = promoted_ff;
      count_in     = count_ff;
      evicted_in   = evicted_ff;
      ev_key_in    = ev_key_ff;
      occ_in       = occ_ff;

      if (csr_write_en) begin
         case (csr_index)
            CSR_HIT_THRESHOLD: thr_in = csr_data;
            CSR_CAPACITY:      cap_in = csr_data[CAP_REG_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in   = req_key[KEY_BITS-1:0];
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (fire) begin
               if (!hit && !full) begin
                  held_in = held_ff + HW'(1);
                  occ_in  = OCC_W'(held_ff + HW'(1));
               end else begin
                  occ_in  = OCC_W'(held_ff);
               end
               rsp_valid_in = 1'b1;
               hit_in       = hit;
               promoted_in  = promote;
               count_in     = COUNT_OUT_W'(new_count);
               evicted_in   = !hit && full;
               ev_key_in    = (!hit && full) ? KEY_W'(rear_key) : '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         thr_ff       <= HIT_THRESHOLD_RESET;
         cap_ff       <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         thr_ff       <= thr_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff      <= key_in;
      hit_ff      <= hit_in;
      promoted_ff <= promoted_in;
      count_ff    <= count_in;
      evicted_ff  <= evicted_in;
      ev_key_ff   <= ev_key_in;
      occ_ff      <= occ_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_promoted    = promoted_ff;
   assign rsp_hit_count   = count_ff;
   assign rsp_evicted     = evicted_ff;
   assign rsp_evicted_key = ev_key_ff;
   assign rsp_occupancy   = occ_ff;

endmodule
